[sv/edit_distance_matcher_defines.svh]
// Assertion macros shared by the edit distance matcher modules.
`ifndef EDIT_DISTANCE_MATCHER_DEFINES_SVH
`define EDIT_DISTANCE_MATCHER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define EDM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("edm: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define EDM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("edm: next-cycle check failed");

`endif

[sv/edm_pkg.sv]
// Shared types, constants and helpers of the edit distance matcher.
`default_nettype none

package edm_pkg;

    localparam int QUERY_MAX           = 16;
    localparam int MAX_WORD_LENGTH_DEF = 16;
    localparam int SYM_W               = 8;
    localparam int DIST_W              = 5;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 64;

    localparam logic [DIST_W-1:0] CELL_CAP      = 5'd31;
    localparam logic [DIST_W-1:0] DIST_SAT      = 5'd16;
    localparam logic [DIST_W-1:0] DEFAULT_LIMIT = 5'd2;

    localparam logic [CFG_IDX_W-1:0] REG_QUERY_LENGTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_BYTES_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_BYTES_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_LIMIT   = 3'd3;

    // One candidate byte as it travels down the row of cells.
    typedef struct packed {
        logic [SYM_W-1:0]  sym;
        logic              start;
        logic              empty;
        logic              skip;
        logic              emit;
        logic              ovf;
        logic [DIST_W-1:0] left;
        logic [DIST_W-1:0] diag;
        logic [DIST_W-1:0] res;
    } t_token;

    function automatic logic [DIST_W-1:0] cap_cell(input logic [DIST_W:0] v);
        return (v > {1'b0, CELL_CAP}) ? CELL_CAP : v[DIST_W-1:0];
    endfunction

endpackage

`default_nettype wire

[sv/edm_in_if.sv]
// Input channel carrying one candidate byte per transaction.
`default_nettype none

interface edm_in_if;
    logic                       valid;
    logic                       ready;
    logic [edm_pkg::SYM_W-1:0]  symbol;
    logic                       first_of_word;
    logic                       last_of_word;
    logic                       word_is_empty;

    modport source (output valid, symbol, first_of_word, last_of_word, word_is_empty,
                    input ready);
    modport sink   (input valid, symbol, first_of_word, last_of_word, word_is_empty,
                    output ready);
endinterface

`default_nettype wire

[sv/edm_out_if.sv]
// Output channel carrying one match result per transaction.
`default_nettype none

interface edm_out_if;
    logic                        valid;
    logic                        ready;
    logic [edm_pkg::DIST_W-1:0]  distance;
    logic                        within_limit;
    logic                        word_too_long;

    modport source (output valid, distance, within_limit, word_too_long, input ready);
    modport sink   (input valid, distance, within_limit, word_too_long, output ready);
endinterface

`default_nettype wire

[sv/edm_head.sv]
// Column zero of the row: candidate length counter and overflow tracking.
`default_nettype none

`include "edit_distance_matcher_defines.svh"

module edm_head #(
    parameter int MAX_WORD_LENGTH = edm_pkg::MAX_WORD_LENGTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [edm_pkg::SYM_W-1:0]     i_symbol,
    input  logic                          i_first,
    input  logic                          i_last,
    input  logic                          i_empty,
    input  logic [edm_pkg::DIST_W-1:0]    i_len,
    output edm_pkg::t_token               o_tok
);

    localparam int CW = $clog2(MAX_WORD_LENGTH + 1);

    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            r_ovf;
    logic            n_ovf;
    edm_pkg::t_token r_tok;
    edm_pkg::t_token n_tok;
    logic            w_start;
    logic [CW-1:0]   w_base;
    logic [7:0]      w_base_ext;
    logic [7:0]      w_next_ext;

    assign w_start    = i_first | i_empty;
    assign w_base     = w_start ? '0 : r_count;
    assign w_base_ext = 8'(w_base);
    assign w_next_ext = 8'(w_base) + 8'd1;

    always_comb begin
        n_count     = w_base;
        n_ovf       = w_start ? 1'b0 : r_ovf;
        n_tok.sym   = i_symbol;
        n_tok.start = w_start;
        n_tok.empty = i_empty;
        n_tok.skip  = 1'b0;
        n_tok.emit  = i_last | i_empty;
        n_tok.diag  = edm_pkg::cap_cell(w_base_ext[edm_pkg::DIST_W:0] |
                                        {1'b0, {edm_pkg::DIST_W{|w_base_ext[7:6]}}});
        n_tok.left  = n_tok.diag;
        if (i_empty) begin
            n_count    = '0;
            n_ovf      = 1'b0;
            n_tok.left = '0;
            n_tok.diag = '0;
        end else if (w_base >= CW'(MAX_WORD_LENGTH)) begin
            // Bytes past the bound leave the row untouched.
            n_ovf      = 1'b1;
            n_tok.skip = 1'b1;
        end else begin
            n_count    = CW'(w_next_ext);
            n_tok.left = edm_pkg::cap_cell(w_next_ext[edm_pkg::DIST_W:0] |
                                           {1'b0, {edm_pkg::DIST_W{|w_next_ext[7:6]}}});
        end
        n_tok.ovf = n_ovf;
        n_tok.res = (i_len == '0) ? n_tok.left : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_load) begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

    `EDM_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(MAX_WORD_LENGTH))

endmodule

`default_nettype wire

[sv/edm_cell.sv]
// One query column of the row: holds its distance entry and updates it per byte.
`default_nettype none

module edm_cell #(
    parameter int COL = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  edm_pkg::t_token               i_tok,
    input  logic [edm_pkg::SYM_W-1:0]     i_qbyte,
    input  logic [edm_pkg::DIST_W-1:0]    i_len,
    output edm_pkg::t_token               o_tok
);

    logic [edm_pkg::DIST_W-1:0] r_col;
    logic [edm_pkg::DIST_W-1:0] w_above;
    logic [edm_pkg::DIST_W-1:0] w_new;
    logic [edm_pkg::DIST_W:0]   w_sub;
    logic [edm_pkg::DIST_W:0]   w_del;
    logic [edm_pkg::DIST_W:0]   w_ins;
    logic [edm_pkg::DIST_W:0]   w_best;
    edm_pkg::t_token            r_tok;
    edm_pkg::t_token            n_tok;

    always_comb begin
        // A new word sees the freshly initialized row entry.
        w_above = i_tok.start ? edm_pkg::DIST_W'(COL) : r_col;
        w_sub   = {1'b0, i_tok.diag} + {{edm_pkg::DIST_W{1'b0}}, (i_qbyte != i_tok.sym)};
        w_del   = {1'b0, w_above} + 6'd1;
        w_ins   = {1'b0, i_tok.left} + 6'd1;
        w_best  = w_sub;
        if (w_del < w_best) begin
            w_best = w_del;
        end
        if (w_ins < w_best) begin
            w_best = w_ins;
        end
        if (i_tok.empty) begin
            w_new = edm_pkg::DIST_W'(COL);
        end else if (i_tok.skip) begin
            w_new = w_above;
        end else begin
            w_new = edm_pkg::cap_cell(w_best);
        end
        n_tok      = i_tok;
        n_tok.left = w_new;
        n_tok.diag = w_above;
        if (i_len == edm_pkg::DIST_W'(COL)) begin
            n_tok.res = w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= edm_pkg::DIST_W'(COL);
        end else if (i_load) begin
            r_col <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

[sv/edit_distance_matcher.sv]
// Path: a byte passes 17 registered stages, the head and then the cells of the row.
// Throughput: one candidate byte per cycle; the row of cells is a pipeline with per-stage
// valid bits, so a waiting result only stops the stages that are full behind it.
// Reset: synchronous, active low; the row returns to entry j = j, counters clear,
// query registers clear and the distance limit returns to 2.
`default_nettype none

`include "edit_distance_matcher_defines.svh"

module edit_distance_matcher #(
    parameter int MAX_WORD_LENGTH = edm_pkg::MAX_WORD_LENGTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [edm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [edm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    edm_in_if.sink                            i_sym_ch,
    edm_out_if.source                         o_res_ch
);

    localparam int Q = edm_pkg::QUERY_MAX;

    logic [edm_pkg::DIST_W-1:0]  r_qlen;
    logic [63:0]                 r_qlo;
    logic [63:0]                 r_qhi;
    logic [edm_pkg::DIST_W-1:0]  r_limit;
    logic [127:0]                w_query;
    logic [edm_pkg::DIST_W-1:0]  w_len;
    logic [Q:0]                  r_vld;
    logic [Q:0]                  n_vld;
    logic [Q:0]                  w_leave;
    logic [Q:0]                  w_load;
    edm_pkg::t_token             w_tok [0:Q];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen  <= '0;
            r_qlo   <= '0;
            r_qhi   <= '0;
            r_limit <= edm_pkg::DEFAULT_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                edm_pkg::REG_QUERY_LENGTH:     r_qlen  <= i_cfg_data[edm_pkg::DIST_W-1:0];
                edm_pkg::REG_QUERY_BYTES_LOW:  r_qlo   <= i_cfg_data;
                edm_pkg::REG_QUERY_BYTES_HIGH: r_qhi   <= i_cfg_data;
                edm_pkg::REG_DISTANCE_LIMIT:   r_limit <= i_cfg_data[edm_pkg::DIST_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_query = {r_qhi, r_qlo};
    assign w_len   = (r_qlen > edm_pkg::DIST_W'(Q)) ? edm_pkg::DIST_W'(Q) : r_qlen;

    // A stage empties when its token moves on; the last stage drops tokens with no result.
    assign w_leave[Q] = r_vld[Q] && (!w_tok[Q].emit || o_res_ch.ready);

    for (genvar k = 0; k < Q; k++) begin : g_flow
        assign w_leave[k]  = r_vld[k] && (!r_vld[k+1] || w_leave[k+1]);
        assign w_load[k+1] = w_leave[k];
    end

    assign i_sym_ch.ready = !r_vld[0] || w_leave[0];
    assign w_load[0]      = i_sym_ch.valid && i_sym_ch.ready;

    always_comb begin
        n_vld = w_load | (r_vld & ~w_leave);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    edm_head #(
        .MAX_WORD_LENGTH (MAX_WORD_LENGTH)
    ) u_head (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load[0]),
        .i_symbol (i_sym_ch.symbol),
        .i_first  (i_sym_ch.first_of_word),
        .i_last   (i_sym_ch.last_of_word),
        .i_empty  (i_sym_ch.word_is_empty),
        .i_len    (w_len),
        .o_tok    (w_tok[0])
    );

    for (genvar j = 1; j <= Q; j++) begin : g_cell
        edm_cell #(
            .COL (j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (w_load[j]),
            .i_tok   (w_tok[j-1]),
            .i_qbyte (w_query[8*(j-1) +: 8]),
            .i_len   (w_len),
            .o_tok   (w_tok[j])
        );
    end

    assign o_res_ch.valid         = r_vld[Q] && w_tok[Q].emit;
    assign o_res_ch.word_too_long = w_tok[Q].ovf;
    assign o_res_ch.within_limit  = !w_tok[Q].ovf && (w_tok[Q].res <= r_limit);
    assign o_res_ch.distance      = (w_tok[Q].ovf || w_tok[Q].res > edm_pkg::DIST_SAT) ?
                                    edm_pkg::DIST_SAT : w_tok[Q].res;

    `EDM_ASSERT_NOW(a_ready_when_head_free, i_sym_ch.valid && !r_vld[0], i_sym_ch.ready)
    `EDM_ASSERT_NOW(a_close_not_long, o_res_ch.valid, !(o_res_ch.within_limit && o_res_ch.word_too_long))
    `EDM_ASSERT_NEXT(a_empty_word_head, w_load[0] && i_sym_ch.word_is_empty, r_vld[0] && w_tok[0].emit && (w_tok[0].left == '0) && !w_tok[0].ovf)

endmodule

`default_nettype wire
